// ===== src/sfwp_pkg.sv =====
// shared types, constants and helpers for the scale frame weight parser
package sfwp_pkg;

  localparam int COEFF_W  = 24;
  localparam int MAG_W    = 20;
  localparam int RAW_W    = 21;
  localparam int PLACES_W = 4;
  localparam int SCALED_W = 45;
  localparam int PROD_W   = MAG_W + COEFF_W;
  localparam int DIV_W    = 30;
  localparam int CNT_W    = $clog2(PROD_W);

  localparam logic [7:0] START_BYTE = 8'h02;
  localparam logic [7:0] END_BYTE   = 8'h03;
  localparam logic [7:0] MINUS_CHAR = 8'h2D;
  localparam logic [7:0] ZERO_CHAR  = 8'h30;
  localparam logic [7:0] NINE_CHAR  = 8'h39;

  localparam logic [3:0] POS_HUNT      = 4'd0;
  localparam logic [3:0] POS_SIGN      = 4'd1;
  localparam logic [3:0] POS_DIG_FIRST = 4'd2;
  localparam logic [3:0] POS_DIG_LAST  = 4'd7;
  localparam logic [3:0] POS_PLACES    = 4'd8;
  localparam logic [3:0] POS_END       = 4'd11;

  localparam logic [1:0] STATUS_GOOD      = 2'd0;
  localparam logic [1:0] STATUS_NO_END    = 2'd1;
  localparam logic [1:0] STATUS_BAD_DIGIT = 2'd2;

  typedef struct packed {
    logic [1:0]          status;
    logic                neg;
    logic [MAG_W-1:0]    mag;
    logic [PLACES_W-1:0] places;
  } job_t;

  function automatic logic [DIV_W-1:0] pow10(input logic [PLACES_W-1:0] p);
    logic [DIV_W-1:0] r;
    case (p)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// ===== src/sfwp_front.sv =====
// frame parser: hunts for the start byte and collects sign, digits and places
module sfwp_front
  import sfwp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       job_valid,
  output job_t       job
);

  logic [3:0]          pos;
  logic                neg;
  logic [MAG_W-1:0]    mag;
  logic [PLACES_W-1:0] places;
  logic                fault;

  logic                is_digit;
  logic [3:0]          digit;
  logic [MAG_W+3:0]    mag_wide;

  assign is_digit = (rx_byte >= ZERO_CHAR) && (rx_byte <= NINE_CHAR);
  assign digit    = rx_byte[3:0];
  assign mag_wide = ({4'b0, mag} * 24'd10) + {20'b0, digit};

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= POS_HUNT;
      neg    <= 1'b0;
      mag    <= '0;
      places <= '0;
      fault  <= 1'b0;
    end else if (accept) begin
      if (pos == POS_HUNT) begin
        if (rx_byte == START_BYTE) begin
          pos <= POS_SIGN;
        end
      end else if (pos == POS_END) begin
        pos    <= POS_HUNT;
        neg    <= 1'b0;
        mag    <= '0;
        places <= '0;
        fault  <= 1'b0;
      end else begin
        if (pos == POS_SIGN) begin
          neg <= (rx_byte == MINUS_CHAR);
        end else if (pos >= POS_DIG_FIRST && pos <= POS_DIG_LAST) begin
          if (is_digit) begin
            mag <= mag_wide[MAG_W-1:0];
          end else begin
            fault <= 1'b1;
          end
        end else if (pos == POS_PLACES) begin
          if (is_digit) begin
            places <= digit;
          end else begin
            fault <= 1'b1;
          end
        end
        pos <= pos + 4'd1;
      end
    end
  end

  always_comb begin
    job_valid = accept && (pos == POS_END);
    job       = '0;
    if (rx_byte != END_BYTE) begin
      job.status = STATUS_NO_END;
    end else if (fault) begin
      job.status = STATUS_BAD_DIGIT;
    end else begin
      job.status = STATUS_GOOD;
      job.neg    = neg;
      job.mag    = mag;
      job.places = places;
    end
  end

endmodule

// ===== src/sfwp_jobq.sv =====
// two-entry queue of parsed frames between parser and scaler
module sfwp_jobq
  import sfwp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t wdata,
  output logic full,
  input  logic pop,
  output logic empty,
  output job_t rdata
);

  job_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job queue read while empty");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
      (count != 2'd3) && ((count == 2'd1) == (wr_ptr != rd_ptr)))
    else $error("job queue count out of step with pointers");

endmodule

// ===== src/sfwp_back.sv =====
// scaler: multiply by coefficient, restoring divide by 10^places, result register
module sfwp_back
  import sfwp_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       job_empty,
  input  job_t                       job,
  output logic                       job_pop,
  input  logic [COEFF_W-1:0]         coeff,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 status,
  output logic signed [RAW_W-1:0]    raw_value,
  output logic [PLACES_W-1:0]        decimal_places,
  output logic signed [SCALED_W-1:0] scaled_weight
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0]        state;
  job_t              cur;
  logic [PROD_W-1:0] prod;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [CNT_W-1:0]  cnt;
  logic              out_valid;

  logic [DIV_W:0]    trial;
  logic              ge;

  assign trial   = {rem, prod[PROD_W-1]};
  assign ge      = trial >= {1'b0, divisor};
  assign job_pop = (state == ST_IDLE) && !job_empty;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!job_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (cnt == CNT_W'(PROD_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || pop) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        cur     <= job;
        divisor <= pow10(job.places);
      end
      ST_MUL: begin
        prod <= PROD_W'(cur.mag) * PROD_W'(coeff);
        rem  <= '0;
        cnt  <= '0;
      end
      ST_DIV: begin
        rem  <= ge ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
        prod <= {prod[PROD_W-2:0], ge};
        cnt  <= cnt + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && (!out_valid || pop)) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && (!out_valid || pop)) begin
      status         <= cur.status;
      decimal_places <= cur.places;
      raw_value      <= cur.neg ? -$signed({1'b0, cur.mag}) : $signed({1'b0, cur.mag});
      scaled_weight  <= cur.neg ? -$signed({1'b0, prod}) : $signed({1'b0, prod});
    end
  end

endmodule

// ===== src/scale_frame_weight_parser.sv =====
// top level of the scale frame weight parser with its calibration register
// Usage: received serial bytes enter through push/full/rx_byte, one item per
// clock while full is low. A frame is 0x02, sign, six ascii digits, a places
// digit, two ignored bytes and 0x03; anything before 0x02 is dropped.
// On the last byte of each frame one result item is queued: status,
// raw_value, decimal_places and scaled_weight, read through empty/pop.
// Bytes are taken at one per cycle while full is low; for each frame the
// scaler loads the job, multiplies, runs 44 restoring divide steps and writes
// back the result, and takes the next frame only once it is back in idle.
// A two-entry frame queue sits between parser and scaler; full rises when it
// holds two frames, which only happens if frames arrive faster than the scaler
// finishes them or the result side stalls. A result waits in its output register
// until popped, and the scaler holds its next result behind it.
// cal_coeff lies at byte address 0 of the apb port; the user must write it only
// while the block is idle, which the block does not enforce. Reset empties
// the queues, returns the parser to hunting and loads cal_coeff with 1.0.
module scale_frame_weight_parser
  import sfwp_pkg::*;
#(
  parameter int COEFF_FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 rx_byte,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 status,
  output logic signed [RAW_W-1:0]    raw_value,
  output logic [PLACES_W-1:0]        decimal_places,
  output logic signed [SCALED_W-1:0] scaled_weight
);

  localparam logic [COEFF_W-1:0] COEFF_ONE =
    (COEFF_FRAC_BITS >= COEFF_W) ? {COEFF_W{1'b1}} : COEFF_W'(64'd1 << COEFF_FRAC_BITS);

  logic [COEFF_W-1:0] cal_coeff;
  logic               accept;
  logic               fq_push;
  job_t               fq_wdata;
  logic               fq_pop;
  logic               fq_empty;
  job_t               fq_rdata;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {8'b0, cal_coeff} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_coeff <= COEFF_ONE;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      cal_coeff <= pwdata[COEFF_W-1:0];
    end
  end

  assign accept = push && !full;

  sfwp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .job_valid (fq_push),
    .job       (fq_wdata)
  );

  sfwp_jobq u_jobq (
    .clk   (clk),
    .rst   (rst),
    .push  (fq_push),
    .wdata (fq_wdata),
    .full  (full),
    .pop   (fq_pop),
    .empty (fq_empty),
    .rdata (fq_rdata)
  );

  sfwp_back u_back (
    .clk            (clk),
    .rst            (rst),
    .job_empty      (fq_empty),
    .job            (fq_rdata),
    .job_pop        (fq_pop),
    .coeff          (cal_coeff),
    .empty          (empty),
    .pop            (pop),
    .status         (status),
    .raw_value      (raw_value),
    .decimal_places (decimal_places),
    .scaled_weight  (scaled_weight)
  );

endmodule

// ===== verif/scale_frame_weight_parser_test.sv =====
// self-checking testbench for the scale frame weight parser: byte frames in, weight items out
module scale_frame_weight_parser_test;
  import sfwp_pkg::*;

  localparam logic [2:0] COEFF_ADDR     = 3'd0;
  localparam logic [2:0] SPARE_ADDR     = 3'd4;
  localparam logic [7:0] PLUS_CHAR      = 8'h2B;
  localparam int         LATENCY_CYCLES = 64;
  localparam int         WATCHDOG_LIMIT = 2000;
  localparam int         FRAMES_PER_RUN = 22;

  typedef logic [11:0][7:0] frame_t;

  typedef struct {
    logic [1:0]                 status;
    logic signed [RAW_W-1:0]    raw;
    logic [PLACES_W-1:0]        places;
    logic signed [SCALED_W-1:0] scaled;
  } weight_item_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       psel = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite = 1'b0;
  logic [2:0]                 paddr = '0;
  logic [31:0]                pwdata = '0;
  logic [31:0]                prdata;
  logic                       pready;
  logic                       push = 1'b0;
  logic                       full;
  logic [7:0]                 rx_byte = '0;
  logic                       empty;
  logic                       pop = 1'b0;
  logic [1:0]                 status;
  logic signed [RAW_W-1:0]    raw_value;
  logic [PLACES_W-1:0]        decimal_places;
  logic signed [SCALED_W-1:0] scaled_weight;

  logic [7:0]          byte_q[$];
  weight_item_t        weight_q[$];
  weight_item_t        want;
  int                  bytes_queued = 0;
  int                  bytes_taken = 0;
  int                  err_cnt = 0;
  int                  tx_wait = 0;
  int                  rx_wait = 0;
  int                  tx_gap_max = 0;
  int                  rx_gap_max = 0;
  int                  idle_cycles = 0;

  logic [COEFF_W-1:0]  coeff_reg = COEFF_W'(1 << 16);
  logic [3:0]          frame_pos = POS_HUNT;
  logic                frame_neg = 1'b0;
  logic [MAG_W-1:0]    frame_mag = '0;
  logic [PLACES_W-1:0] frame_places = '0;
  logic                frame_fault = 1'b0;

  scale_frame_weight_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .rx_byte       (rx_byte),
    .empty         (empty),
    .pop           (pop),
    .status        (status),
    .raw_value     (raw_value),
    .decimal_places(decimal_places),
    .scaled_weight (scaled_weight)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic frame_t make_frame(logic [7:0] sgn, int unsigned mag, logic [7:0] pl,
                                        logic [7:0] pad, logic [7:0] tail);
    frame_t f;
    f[0] = START_BYTE;
    f[1] = sgn;
    for (int i = 7; i >= 2; i--) begin
      f[i] = ZERO_CHAR + 8'(mag % 10);
      mag = mag / 10;
    end
    f[8]  = pl;
    f[9]  = pad;
    f[10] = ~pad;
    f[11] = tail;
    return f;
  endfunction

  task automatic parse_rx_byte(input logic [7:0] b);
    weight_item_t        res;
    logic                is_digit;
    logic [PROD_W-1:0]   product;
    logic [PROD_W-1:0]   divisor;
    logic [SCALED_W-1:0] magnitude;
    logic [RAW_W-1:0]    raw_mag;
    is_digit = (b >= ZERO_CHAR) && (b <= NINE_CHAR);
    if (frame_pos == POS_HUNT) begin
      if (b == START_BYTE) frame_pos = POS_SIGN;
    end else if (frame_pos == POS_END) begin
      res.status = STATUS_GOOD;
      res.raw    = '0;
      res.places = '0;
      res.scaled = '0;
      if (b != END_BYTE) begin
        res.status = STATUS_NO_END;
      end else if (frame_fault) begin
        res.status = STATUS_BAD_DIGIT;
      end else begin
        product = PROD_W'(frame_mag) * PROD_W'(coeff_reg);
        divisor = PROD_W'(1);
        repeat (frame_places) divisor = divisor * PROD_W'(10);
        magnitude  = SCALED_W'(product / divisor);
        raw_mag    = {1'b0, frame_mag};
        res.raw    = frame_neg ? ({RAW_W{1'b0}} - raw_mag) : raw_mag;
        res.scaled = frame_neg ? ({SCALED_W{1'b0}} - magnitude) : magnitude;
        res.places = frame_places;
      end
      weight_q.push_back(res);
      frame_pos    = POS_HUNT;
      frame_neg    = 1'b0;
      frame_mag    = '0;
      frame_places = '0;
      frame_fault  = 1'b0;
    end else begin
      if (frame_pos == POS_SIGN) begin
        frame_neg = (b == MINUS_CHAR);
      end else if (frame_pos <= POS_DIG_LAST) begin
        if (is_digit) frame_mag = MAG_W'(frame_mag * 10 + (b - ZERO_CHAR));
        else frame_fault = 1'b1;
      end else if (frame_pos == POS_PLACES) begin
        if (is_digit) frame_places = PLACES_W'(b - ZERO_CHAR);
        else frame_fault = 1'b1;
      end
      frame_pos = frame_pos + 4'd1;
    end
  endtask

  task automatic queue_byte(input logic [7:0] b);
    byte_q.push_back(b);
    bytes_queued++;
  endtask

  task automatic queue_frame(input frame_t f);
    for (int i = 0; i < 12; i++) queue_byte(f[i]);
  endtask

  task automatic wait_drained();
    while (bytes_taken != bytes_queued || weight_q.size() != 0) @(posedge clk);
  endtask

  task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] wdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (wr && addr == COEFF_ADDR) begin
      coeff_reg = wdata[COEFF_W-1:0];
    end else if (!wr && prdata[COEFF_W-1:0] != coeff_reg) begin
      $error("cal_coeff: expected %0d, got %0d", coeff_reg, prdata[COEFF_W-1:0]);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic queue_directed();
    frame_t f;
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(END_BYTE);
    // largest negative reading, most places, start byte in an ignored slot
    queue_frame(make_frame(MINUS_CHAR, 999999, NINE_CHAR, START_BYTE, END_BYTE));
    // minus zero
    queue_frame(make_frame(MINUS_CHAR, 0, ZERO_CHAR, 8'h00, END_BYTE));
    // start byte as sign, non-digits in digit and places slots
    f = make_frame(START_BYTE, 120456, NINE_CHAR + 8'd1, 8'h55, END_BYTE);
    f[4] = ZERO_CHAR - 8'd1;
    queue_frame(f);
    // bad end marker wins over a digit fault
    queue_frame(make_frame(MINUS_CHAR, 5, 8'hFF, 8'hAA, START_BYTE));
    queue_frame(make_frame(PLUS_CHAR, 999999, ZERO_CHAR, 8'hFF, END_BYTE));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      push    <= 1'b0;
      rx_byte <= '0;
      tx_wait <= 0;
    end else if (!push || !full) begin
      if (tx_wait != 0) begin
        push    <= 1'b0;
        tx_wait <= tx_wait - 1;
      end else if (byte_q.size() != 0) begin
        push    <= 1'b1;
        rx_byte <= byte_q.pop_front();
        tx_wait <= $urandom_range(0, tx_gap_max);
      end else begin
        push <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      pop          <= 1'b0;
      rx_wait      <= 0;
      frame_pos    = POS_HUNT;
      frame_neg    = 1'b0;
      frame_mag    = '0;
      frame_places = '0;
      frame_fault  = 1'b0;
    end else begin
      if (push && !full) begin
        parse_rx_byte(rx_byte);
        bytes_taken++;
      end
      if (pop && !empty) begin
        if (weight_q.size() == 0) begin
          $error("result item with nothing expected: status %0d raw_value %0d", status,
                 raw_value);
          err_cnt++;
        end else begin
          want = weight_q.pop_front();
          if (status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status);
            err_cnt++;
          end
          if (raw_value !== want.raw) begin
            $error("raw_value: expected %0d, got %0d", want.raw, raw_value);
            err_cnt++;
          end
          if (decimal_places !== want.places) begin
            $error("decimal_places: expected %0d, got %0d", want.places, decimal_places);
            err_cnt++;
          end
          if (scaled_weight !== want.scaled) begin
            $error("scaled_weight: expected %0d, got %0d", want.scaled, scaled_weight);
            err_cnt++;
          end
        end
      end
      if (!pop || !empty) begin
        if (rx_wait != 0) begin
          pop     <= 1'b0;
          rx_wait <= rx_wait - 1;
        end else begin
          pop     <= 1'b1;
          rx_wait <= $urandom_range(0, rx_gap_max);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((push && !full) || (pop && !empty)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    frame_t             f;
    logic [7:0]         sgn;
    int unsigned        mag;
    logic [COEFF_W-1:0] coeff_set;
    int                 tx_levels[6];
    int                 rx_levels[6];
    tx_levels = '{7, 0, 3, 7, 0, 7};
    rx_levels = '{0, 7, 3, 7, 0, 2};
    rst = 1'b1;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset coefficient first, then the largest one with junk in the upper bits
    apb_access(1'b0, COEFF_ADDR, '0);
    tx_gap_max = 2;
    rx_gap_max = 5;
    queue_directed();
    wait_drained();
    repeat (LATENCY_CYCLES) @(posedge clk);
    apb_access(1'b1, COEFF_ADDR, 32'hA5FF_FFFF);
    apb_access(1'b0, COEFF_ADDR, '0);
    queue_directed();
    wait_drained();

    for (int p = 0; p < 6; p++) begin
      repeat (LATENCY_CYCLES) @(posedge clk);
      case (p)
        0:       coeff_set = '0;
        1:       coeff_set = COEFF_W'(1);
        2:       coeff_set = {COEFF_W{1'b1}};
        4:       coeff_set = COEFF_W'(1 << 16);
        default: coeff_set = COEFF_W'($urandom_range(0, 24'hFFFFFF));
      endcase
      if (p == 3) apb_access(1'b1, SPARE_ADDR, $urandom);
      apb_access(1'b1, COEFF_ADDR, {8'($urandom_range(0, 255)), coeff_set});
      apb_access(1'b0, COEFF_ADDR, '0);
      tx_gap_max = tx_levels[p];
      rx_gap_max = rx_levels[p];
      for (int n = 0; n < FRAMES_PER_RUN; n++) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 4)) queue_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 3))
          0, 1:    sgn = MINUS_CHAR;
          2:       sgn = PLUS_CHAR;
          default: sgn = 8'($urandom_range(0, 255));
        endcase
        case ($urandom_range(0, 7))
          0:       mag = 0;
          1:       mag = 999999;
          default: mag = $urandom_range(0, 999999);
        endcase
        f = make_frame(sgn, mag, ZERO_CHAR + 8'($urandom_range(0, 9)),
                       8'($urandom_range(0, 255)), END_BYTE);
        if ($urandom_range(0, 9) == 0) f[$urandom_range(0, 11)] = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 19) == 0) f[11] = 8'($urandom_range(0, 255));
        if (n == 5 || $urandom_range(0, 39) == 0) begin
          // hold the sender mid-frame until every result is out
          for (int k = 0; k < 6; k++) queue_byte(f[k]);
          wait_drained();
          for (int k = 6; k < 12; k++) queue_byte(f[k]);
        end else begin
          queue_frame(f);
        end
      end
      wait_drained();
    end

    repeat (LATENCY_CYCLES) @(posedge clk);
    if (err_cnt == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
src/sfwp_pkg.sv
src/sfwp_front.sv
src/sfwp_jobq.sv
src/sfwp_back.sv
src/scale_frame_weight_parser.sv
verif/scale_frame_weight_parser_test.sv
